// ===== design/circle_normal_projection_defines.svh =====
// Assertion macros for the circle normal projection block.
// Both expect signals named clk and rst in the module that uses them.
`ifndef CIRCLE_NORMAL_PROJECTION_DEFINES_SVH
`define CIRCLE_NORMAL_PROJECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define CNP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cnp assertion failed");
`define CNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cnp assertion failed");
`else
`define CNP_ASSERT_IMP(label, ante, cons)
`define CNP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/cnp_pkg.sv =====
package cnp_pkg;

  // Fixed point format; only the reset radius depends on it.
  localparam int FRAC_BITS = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [30:0] RADIUS_RESET = 31'(1) << FRAC_BITS;

  // Datapath widths.
  localparam int A_W    = 64;          // |n|^2
  localparam int BM_W   = 65;          // |B|
  localparam int D_W    = 130;         // discriminant
  localparam int ROOT_W = 65;          // floor(sqrt(D))
  localparam int REM_W  = ROOT_W + 4;  // square root partial remainder

  // Pipeline depths.
  localparam int FRONT_STAGES = 7;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = 34;
  localparam int PLACE_STAGES = DIV_STAGES + 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_HIT   = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

  // Per-item values that ride along the pipeline.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] nx;
    logic signed [32:0] ny;
    logic [A_W-1:0]     a;
    logic [BM_W-1:0]    bm;
    logic               bpos;
    status_t            status;
  } side_t;

endpackage

// ===== design/cnp_in_if.sv =====
interface cnp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;

  modport source (output valid, point_x, point_y, dir_x, dir_y, input ready);
  modport sink (input valid, point_x, point_y, dir_x, dir_y, output ready);
endinterface

// ===== design/cnp_out_if.sv =====
interface cnp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] proj_x;
  logic signed [31:0] proj_y;
  logic [1:0]         status;

  modport source (output valid, proj_x, proj_y, status, input ready);
  modport sink (input valid, proj_x, proj_y, status, output ready);
endinterface

// ===== design/cnp_front.sv =====
module cnp_front import cnp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        radius,
  output logic               out_valid,
  output side_t              out_side,
  output logic [D_W-1:0]     out_dm
);

  logic [FRONT_STAGES:1] v;
  side_t                 sd [1:FRONT_STAGES];
  side_t                 sd1_next, sd3_next, sd4_next, sd7_next;

  logic signed [32:0] ux1, uy1;
  logic signed [64:0] nxux2;
  logic signed [65:0] nyuy2;
  logic signed [63:0] nxsq2;
  logic signed [65:0] nysq2, uxsq2, uysq2;
  logic [61:0]        rsq2;
  logic signed [66:0] b3, c3;
  logic [65:0]        cm4;
  logic               cn4, cn5, cn6;
  logic [63:0]        bhh5;
  logic [64:0]        bhl5;
  logic [65:0]        bll5;
  logic [63:0]        ahh5, ahl5;
  logic [65:0]        alh5, all5;
  logic [D_W-1:0]     b2_6, ac6, dm7;
  logic [D_W:0]       dsum;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[FRONT_STAGES-1:1], in_valid};
    end
  end

  // D = B^2 - A*C with the sign of C folded in.
  assign dsum = cn6 ? ({1'b0, b2_6} + {1'b0, ac6}) : ({1'b0, b2_6} - {1'b0, ac6});

  // Side values of the stages that fill in a field of their own.
  always_comb begin
    sd1_next        = '0;
    sd1_next.px     = point_x;
    sd1_next.py     = point_y;
    sd1_next.nx     = dir_y;
    sd1_next.ny     = -{dir_x[31], dir_x};
    sd1_next.status = (dir_x == '0 && dir_y == '0) ? ST_ZERO_DIR : ST_OK;

    sd3_next   = sd[2];
    sd3_next.a = 64'(nxsq2) + 64'(nysq2);

    sd4_next      = sd[3];
    sd4_next.bm   = b3[66] ? 65'(-b3) : 65'(b3);
    sd4_next.bpos = !b3[66] && (b3 != '0);

    sd7_next = sd[6];
    if (sd[6].status == ST_OK && dsum[D_W]) begin
      sd7_next.status = ST_NO_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Normal vector and offset from the center.
      sd[1] <= sd1_next;
      ux1   <= {point_x[31], point_x} - {center_x[31], center_x};
      uy1   <= {point_y[31], point_y} - {center_y[31], center_y};

      // Elementary products.
      sd[2] <= sd[1];
      nxux2 <= $signed(sd[1].nx) * ux1;
      nyuy2 <= $signed(sd[1].ny) * uy1;
      nxsq2 <= $signed(sd[1].nx) * $signed(sd[1].nx);
      nysq2 <= $signed(sd[1].ny) * $signed(sd[1].ny);
      uxsq2 <= ux1 * ux1;
      uysq2 <= uy1 * uy1;
      rsq2  <= radius * radius;

      // A, B and C.
      sd[3] <= sd3_next;
      b3    <= 67'(nxux2) + 67'(nyuy2);
      c3    <= 67'(uxsq2) + 67'(uysq2) - 67'(rsq2);

      // Magnitudes for the wide products.
      sd[4] <= sd4_next;
      cm4   <= c3[66] ? 66'(-c3) : 66'(c3);
      cn4   <= c3[66];

      // Partial products of B^2 and A*|C| on 33-bit limbs.
      sd[5] <= sd[4];
      bhh5  <= sd[4].bm[64:33] * sd[4].bm[64:33];
      bhl5  <= sd[4].bm[64:33] * sd[4].bm[32:0];
      bll5  <= sd[4].bm[32:0] * sd[4].bm[32:0];
      ahh5  <= sd[4].a[63:33] * cm4[65:33];
      ahl5  <= sd[4].a[63:33] * cm4[32:0];
      alh5  <= sd[4].a[32:0] * cm4[65:33];
      all5  <= sd[4].a[32:0] * cm4[32:0];
      cn5   <= cn4;

      // Partial product sums.
      sd[6] <= sd[5];
      b2_6  <= (130'(bhh5) << 66) + (130'(bhl5) << 34) + 130'(bll5);
      ac6   <= (130'(ahh5) << 66) + ((130'(ahl5) + 130'(alh5)) << 33) + 130'(all5);
      cn6   <= cn5;

      // Discriminant and its sign.
      sd[7] <= sd7_next;
      dm7   <= dsum[D_W-1:0];
    end
  end

  assign out_valid = v[FRONT_STAGES];
  assign out_side  = sd[FRONT_STAGES];
  assign out_dm    = dm7;

endmodule

// ===== design/cnp_sqrt.sv =====
module cnp_sqrt import cnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [D_W-1:0]    in_dm,
  output logic              out_valid,
  output side_t             out_side,
  output logic [ROOT_W-1:0] out_root
);

  // One result bit per stage, two radicand bits consumed per stage.
  logic [SQRT_STAGES:1] v;
  side_t                sd   [1:SQRT_STAGES];
  logic [REM_W-1:0]     rem  [1:SQRT_STAGES];
  logic [ROOT_W-1:0]    root [1:SQRT_STAGES];
  logic [D_W-1:0]       dd   [1:SQRT_STAGES];

  side_t             sin   [0:SQRT_STAGES-1];
  logic [REM_W-1:0]  rin   [0:SQRT_STAGES-1];
  logic [ROOT_W-1:0] qin   [0:SQRT_STAGES-1];
  logic [D_W-1:0]    din   [0:SQRT_STAGES-1];
  logic [REM_W-1:0]  rsh   [0:SQRT_STAGES-1];
  logic [REM_W-1:0]  trial [0:SQRT_STAGES-1];
  logic              ge    [0:SQRT_STAGES-1];

  // Stage inputs and the trial subtraction of each stage.
  always_comb begin
    sin[0] = in_side;
    rin[0] = '0;
    qin[0] = '0;
    din[0] = in_dm;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      sin[k] = sd[k];
      rin[k] = rem[k];
      qin[k] = root[k];
      din[k] = dd[k];
    end
    for (int k = 0; k < SQRT_STAGES; k++) begin
      rsh[k]   = {rin[k][REM_W-3:0], din[k][D_W-1 -: 2]};
      trial[k] = {2'b00, qin[k], 2'b01};
      ge[k]    = rsh[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[SQRT_STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sd[k+1]   <= sin[k];
        rem[k+1]  <= ge[k] ? (rsh[k] - trial[k]) : rsh[k];
        root[k+1] <= {qin[k][ROOT_W-2:0], ge[k]};
        dd[k+1]   <= din[k] << 2;
      end
    end
  end

  assign out_valid = v[SQRT_STAGES];
  assign out_side  = sd[SQRT_STAGES];
  assign out_root  = root[SQRT_STAGES];

endmodule

// ===== design/cnp_place.sv =====
module cnp_place import cnp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [ROOT_W-1:0]  root,
  input  logic [BM_W-1:0]    bm,
  input  logic               bpos,
  input  logic [A_W-1:0]     a,
  input  logic signed [32:0] n,
  input  logic signed [31:0] p,
  input  logic               pass,
  output logic signed [31:0] proj
);

  typedef struct packed {
    logic [A_W-1:0]     a;
    logic signed [31:0] p;
    logic               neg;
    logic               pass;
    logic               ovf;
  } carry_t;

  localparam logic [DIV_STAGES:0] OFF_SAT = (DIV_STAGES+1)'(1) << DIV_STAGES;

  carry_t           c1, c2, c3, c4;
  carry_t           c4_next;
  logic [BM_W-1:0]  diff1;
  logic [31:0]      nm1;
  logic [63:0]      ph2;
  logic [64:0]      pl2;
  logic [96:0]      num3;
  logic [A_W-1:0]   rem4;
  logic [DIV_STAGES-1:0] lo4;
  logic             diffneg;

  carry_t                dc   [1:DIV_STAGES];
  logic [A_W-1:0]        drem [1:DIV_STAGES];
  logic [DIV_STAGES-1:0] dq   [1:DIV_STAGES];
  logic [DIV_STAGES-1:0] dlo  [1:DIV_STAGES];

  carry_t                cin [0:DIV_STAGES-1];
  logic [A_W-1:0]        rin [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] qin [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] lin [0:DIV_STAGES-1];
  logic [A_W:0]          rs  [0:DIV_STAGES-1];
  logic                  ge  [0:DIV_STAGES-1];

  logic [DIV_STAGES:0] off;
  logic signed [35:0]  sum;
  logic signed [31:0]  sat;

  assign diffneg = root < bm;

  // The quotient overflows when the high part of the numerator reaches A.
  always_comb begin
    c4_next     = c3;
    c4_next.ovf = {1'b0, num3[96:DIV_STAGES]} >= c3.a;
  end

  // Numerator N*|n| + A/2, then a compare for quotient overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      c1.a    <= a;
      c1.p    <= p;
      c1.neg  <= (bpos ? diffneg : !diffneg) ^ n[32];
      c1.pass <= pass;
      c1.ovf  <= 1'b0;
      diff1   <= diffneg ? (bm - root) : (root - bm);
      nm1     <= n[32] ? 32'(-n) : 32'(n);

      c2  <= c1;
      ph2 <= diff1[64:33] * nm1;
      pl2 <= diff1[32:0] * nm1;

      c3   <= c2;
      num3 <= (97'(ph2) << 33) + 97'(pl2) + 97'(c2.a >> 1);

      c4   <= c4_next;
      rem4 <= {1'b0, num3[96:DIV_STAGES]};
      lo4  <= num3[DIV_STAGES-1:0];
    end
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    cin[0] = c4;
    rin[0] = rem4;
    qin[0] = '0;
    lin[0] = lo4;
    for (int k = 1; k < DIV_STAGES; k++) begin
      cin[k] = dc[k];
      rin[k] = drem[k];
      qin[k] = dq[k];
      lin[k] = dlo[k];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      rs[k] = {rin[k], lin[k][DIV_STAGES-1]};
      ge[k] = rs[k] >= {1'b0, cin[k].a};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dc[k+1]   <= cin[k];
        drem[k+1] <= ge[k] ? A_W'(rs[k] - {1'b0, cin[k].a}) : rs[k][A_W-1:0];
        dq[k+1]   <= {qin[k][DIV_STAGES-2:0], ge[k]};
        dlo[k+1]  <= lin[k] << 1;
      end
    end
  end

  // Apply the offset and saturate to 32 bits.
  always_comb begin
    off = dc[DIV_STAGES].ovf ? OFF_SAT : {1'b0, dq[DIV_STAGES]};
    if (dc[DIV_STAGES].neg) begin
      sum = 36'($signed(dc[DIV_STAGES].p)) - 36'(off);
    end else begin
      sum = 36'($signed(dc[DIV_STAGES].p)) + 36'(off);
    end
    if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
      sat = sum[31:0];
    end else if (sum[35]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj <= dc[DIV_STAGES].pass ? dc[DIV_STAGES].p : sat;
    end
  end

endmodule

// ===== design/circle_normal_projection.sv =====
// Throughput: one item per cycle while the skid is empty; 7 front stages, 65 square
// root stages and 39 placement stages (34 of them division steps) with an output
// register and skid.
// Reset: synchronous rst clears all valid bits, also those of the output register and skid;
// center_x and center_y reset to 0 and radius to 1.0. No clearing pass is needed.
`include "circle_normal_projection_defines.svh"

module circle_normal_projection import cnp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cnp_in_if.sink                points,
  cnp_out_if.source             projections
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    status_t            st;
  } result_t;

  logic signed [31:0] center_x, center_y;
  logic [30:0]        radius;

  logic              en;
  logic              f_valid;
  side_t             f_side;
  logic [D_W-1:0]    f_dm;
  logic              s_valid;
  side_t             s_side;
  logic [ROOT_W-1:0] s_root;
  logic              s_pass;
  logic signed [31:0] proj_x, proj_y;

  logic [PLACE_STAGES:1] pv;
  status_t               pst [1:PLACE_STAGES];

  logic    fv;
  result_t fres;
  logic    ov, sk_v, take;
  result_t od, sk;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_wdata;
        CFG_CENTER_Y: center_y <= cfg_wdata;
        CFG_RADIUS:   radius   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid holds an item.
  assign en            = !sk_v;
  assign points.ready  = !sk_v;

  cnp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (points.valid),
    .point_x  (points.point_x),
    .point_y  (points.point_y),
    .dir_x    (points.dir_x),
    .dir_y    (points.dir_y),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .out_valid(f_valid),
    .out_side (f_side),
    .out_dm   (f_dm)
  );

  cnp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .in_side  (f_side),
    .in_dm    (f_dm),
    .out_valid(s_valid),
    .out_side (s_side),
    .out_root (s_root)
  );

  assign s_pass = (s_side.status != ST_OK);

  cnp_place u_place_x (
    .clk (clk),
    .en  (en),
    .root(s_root),
    .bm  (s_side.bm),
    .bpos(s_side.bpos),
    .a   (s_side.a),
    .n   (33'($signed(s_side.nx))),
    .p   (s_side.px),
    .pass(s_pass),
    .proj(proj_x)
  );

  cnp_place u_place_y (
    .clk (clk),
    .en  (en),
    .root(s_root),
    .bm  (s_side.bm),
    .bpos(s_side.bpos),
    .a   (s_side.a),
    .n   (s_side.ny),
    .p   (s_side.py),
    .pass(s_pass),
    .proj(proj_y)
  );

  // Valid and status follow the placement units.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[PLACE_STAGES-1:1], s_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pst[1] <= s_side.status;
      for (int k = 1; k < PLACE_STAGES; k++) begin
        pst[k+1] <= pst[k];
      end
    end
  end

  assign fv      = pv[PLACE_STAGES];
  assign fres.x  = proj_x;
  assign fres.y  = proj_y;
  assign fres.st = pst[PLACE_STAGES];

  // Output register with a one-item skid behind it.
  assign take = ov && projections.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      sk_v <= 1'b0;
    end else if (sk_v) begin
      if (take) begin
        sk_v <= 1'b0;
      end
    end else if (fv) begin
      if (!ov || take) begin
        ov <= 1'b1;
      end else begin
        sk_v <= 1'b1;
      end
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (take) begin
        od <= sk;
      end
    end else if (fv) begin
      if (!ov || take) begin
        od <= fres;
      end else begin
        sk <= fres;
      end
    end
  end

  assign projections.valid  = ov;
  assign projections.proj_x = od.x;
  assign projections.proj_y = od.y;
  assign projections.status = od.st;

  `CNP_ASSERT_IMP(a_skid_behind_output, sk_v, ov)
  `CNP_ASSERT_IMP(a_skid_fills_on_stall, $rose(sk_v), $past(ov && !projections.ready))
  `CNP_ASSERT_NEXT(a_last_stage_holds, fv && !en, fv)

endmodule
